/* rtl/skfs_pkg.sv */
// Shared types, codes and constants of the servo keyframe sequencer.
`default_nettype none

package skfs_pkg;

  localparam int NUM_AXES = 4;

  typedef logic [7:0] angle_t;
  // One pose: axis 0 (shoulder) in the lowest byte, then base, elbow, gripper.
  typedef logic [NUM_AXES-1:0][7:0] pose_t;

  typedef enum logic [2:0] {
    OP_SET_POSE  = 3'd0,
    OP_BEGIN_REC = 3'd1,
    OP_STORE     = 3'd2,
    OP_START     = 3'd3,
    OP_TICK      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HOMING = 2'd1,
    PH_MOVING = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_STORED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_FINISHED = 3'd3,
    ST_CANCEL   = 3'd4,
    ST_BUSY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_HOME_ONE   = 2'd0,
    CFG_HOME_TWO   = 2'd1,
    CFG_HOME_THREE = 2'd2,
    CFG_HOME_FOUR  = 2'd3
  } cfg_idx_e;

  // One input beat after unpacking.
  typedef struct packed {
    logic [2:0] op;
    logic       cancel;
    pose_t      pose;
  } item_t;

  // Axis and playback state that does not depend on the table depth.
  typedef struct packed {
    pose_t  position;
    pose_t  target;
    phase_e phase;
  } axis_state_t;

  localparam angle_t EMPTY_MARK = 8'hFF;
  localparam angle_t ANGLE_TOP  = 8'd180;

  localparam pose_t LIM_LO     = {8'd0,  8'd95,  8'd110, 8'd0};
  localparam pose_t LIM_HI     = {8'd10, 8'd160, 8'd180, 8'd180};
  localparam pose_t HOME_RESET = {8'd5,  8'd150, 8'd165, 8'd0};
  localparam pose_t POSE_EMPTY = {NUM_AXES{EMPTY_MARK}};

endpackage

`default_nettype wire

/* rtl/servo_keyframe_sequencer.sv */
// Top level of the four-axis servo keyframe sequencer.
//
//  channel  direction  beat contents
//  s_axis   in         tuser: operation[2:0], cancel_request[3]; tdata: pose_one..four
//  m_axis   out        tdata: position_one..four, phase, frame_number, frames_stored, status
//  cfg      in         cfg_index_i selects a home angle, cfg_data_i is its value
//
// One input beat is taken per cycle while the output does not stall; its result is in the
// output register on the next cycle. The next keyframe row is read from the table ahead
// through a registered read, so a settling tick can load it at once. Reset restores the
// default home pose, erases the table through its row valid bits and empties the output
// register. The input stalls only while a result is held with m_axis_tready_i low.
`default_nettype none

module servo_keyframe_sequencer
  import skfs_pkg::*;
#(
  parameter int NUM_FRAMES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // pose_one, pose_two, pose_three, pose_four
  input  wire logic [3:0]  s_axis_tuser_i,  // operation, cancel_request
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // position_one..four, phase, frame_number, frames_stored, status, zero fill
  output logic [47:0]      m_axis_tdata_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int IW = $clog2(NUM_FRAMES + 1);
  localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [IW-1:0] NF = IW'(NUM_FRAMES);

  pose_t         home_q;
  axis_state_t   st_q, st_d;
  logic [IW-1:0] play_idx_q, play_idx_d;
  logic [IW-1:0] rec_cnt_q, rec_cnt_d;
  status_e       status;
  logic          wr_req;
  logic [AW-1:0] wr_addr;
  logic          accept;
  item_t         item;
  pose_t         slot;
  logic [IW-1:0] next_slot;
  logic [AW-1:0] rd_addr;
  logic          out_valid_q;
  logic [47:0]   out_data_q;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  assign item.op     = s_axis_tuser_i[2:0];
  assign item.cancel = s_axis_tuser_i[3];
  assign item.pose   = s_axis_tdata_i;

  skfs_step #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_step (
    .item_i    (item),
    .cur_i     (st_q),
    .play_idx_i(play_idx_q),
    .rec_cnt_i (rec_cnt_q),
    .home_i    (home_q),
    .slot_i    (slot),
    .nxt_o     (st_d),
    .play_idx_o(play_idx_d),
    .rec_cnt_o (rec_cnt_d),
    .status_o  (status),
    .wr_en_o   (wr_req),
    .wr_addr_o (wr_addr)
  );

  // Look ahead to the row that the next settling tick would load.
  always_comb begin
    if (accept) begin
      next_slot = (st_d.phase == PH_MOVING) ? play_idx_d + IW'(1) : '0;
    end else begin
      next_slot = (st_q.phase == PH_MOVING) ? play_idx_q + IW'(1) : '0;
    end
    rd_addr = (next_slot < NF) ? next_slot[AW-1:0] : '0;
  end

  skfs_frame_store #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept && wr_req),
    .wr_addr_i(wr_addr),
    .wr_data_i(st_q.position),
    .rd_addr_i(rd_addr),
    .rd_data_o(slot)
  );

  // Home angle registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q <= HOME_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HOME_ONE:   home_q[0] <= cfg_data_i;
        CFG_HOME_TWO:   home_q[1] <= cfg_data_i;
        CFG_HOME_THREE: home_q[2] <= cfg_data_i;
        CFG_HOME_FOUR:  home_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Axis and playback state advance on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.position <= HOME_RESET;
      st_q.target   <= '0;
      st_q.phase    <= PH_IDLE;
      play_idx_q    <= '0;
      rec_cnt_q     <= '0;
    end else if (accept) begin
      st_q       <= st_d;
      play_idx_q <= play_idx_d;
      rec_cnt_q  <= rec_cnt_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {5'd0, status, 3'(rec_cnt_d), 3'(play_idx_d), st_d.phase, st_d.position};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/skfs_frame_store.sv */
// Keyframe table: one pose per row, row valid bits and a registered look-ahead read.
`default_nettype none

module skfs_frame_store
  import skfs_pkg::*;
#(
  parameter int NUM_FRAMES = 4,
  localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire pose_t         wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output pose_t              rd_data_o
);

  pose_t                 mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] row_valid_q;
  pose_t                 mem_rd_q;
  logic                  rd_valid_q;
  logic                  byp_q;
  pose_t                 byp_data_q;

  // Rows are written once per store command.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read of the row that the next tick may load.
  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  // Valid bits make an unwritten row read as erased.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= row_valid_q[rd_addr_i];
      byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  // A write to the row being read in the same cycle is forwarded.
  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_valid_q) begin
      rd_data_o = mem_rd_q;
    end else begin
      rd_data_o = POSE_EMPTY;
    end
  end

endmodule

`default_nettype wire

/* rtl/skfs_step.sv */
// Next-state and status logic for one command or tick.
`default_nettype none

module skfs_step
  import skfs_pkg::*;
#(
  parameter int NUM_FRAMES = 4,
  localparam int IW = $clog2(NUM_FRAMES + 1),
  localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  wire item_t         item_i,
  input  wire axis_state_t   cur_i,
  input  wire logic [IW-1:0] play_idx_i,
  input  wire logic [IW-1:0] rec_cnt_i,
  input  wire pose_t         home_i,
  input  wire pose_t         slot_i,
  output axis_state_t        nxt_o,
  output logic [IW-1:0]      play_idx_o,
  output logic [IW-1:0]      rec_cnt_o,
  output status_e            status_o,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o
);

  localparam logic [IW-1:0] NF = IW'(NUM_FRAMES);

  pose_t stepped;
  pose_t clamped;
  pose_t start_tgt;
  logic  moved;

  // Each axis moves one degree toward its target.
  always_comb begin
    stepped = cur_i.position;
    moved   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (cur_i.position[a] < cur_i.target[a]) begin
        stepped[a] = cur_i.position[a] + 8'd1;
        moved      = 1'b1;
      end else if (cur_i.position[a] > cur_i.target[a]) begin
        stepped[a] = cur_i.position[a] - 8'd1;
        moved      = 1'b1;
      end
    end
  end

  // Requested angles are held to the axis limits; home targets to the top angle.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (item_i.pose[a] < LIM_LO[a]) begin
        clamped[a] = LIM_LO[a];
      end else if (item_i.pose[a] > LIM_HI[a]) begin
        clamped[a] = LIM_HI[a];
      end else begin
        clamped[a] = item_i.pose[a];
      end
      start_tgt[a] = (home_i[a] > ANGLE_TOP) ? ANGLE_TOP : home_i[a];
    end
  end

  // Command decode and playback sequencing.
  always_comb begin
    nxt_o      = cur_i;
    play_idx_o = play_idx_i;
    rec_cnt_o  = rec_cnt_i;
    status_o   = ST_NONE;
    wr_en_o    = 1'b0;
    wr_addr_o  = rec_cnt_i[AW-1:0];
    if (cur_i.phase == PH_MOVING && item_i.cancel) begin
      nxt_o.phase = PH_IDLE;
      status_o    = ST_CANCEL;
    end else begin
      case (item_i.op) inside
        OP_TICK: begin
          if (cur_i.phase != PH_IDLE) begin
            nxt_o.position = stepped;
            if (!moved) begin
              // Settled: load the next slot, or finish at its end or an empty row.
              play_idx_o = (cur_i.phase == PH_HOMING) ? '0 : play_idx_i + IW'(1);
              if (play_idx_o >= NF || slot_i[0] == EMPTY_MARK) begin
                nxt_o.phase = PH_IDLE;
                status_o    = ST_FINISHED;
              end else begin
                nxt_o.target = slot_i;
                nxt_o.phase  = PH_MOVING;
              end
            end
          end
        end
        OP_SET_POSE, OP_BEGIN_REC, OP_STORE, OP_START: begin
          if (cur_i.phase != PH_IDLE) begin
            status_o = ST_BUSY;
          end else begin
            case (item_i.op)
              OP_SET_POSE: begin
                nxt_o.position = clamped;
              end
              OP_BEGIN_REC: begin
                rec_cnt_o = '0;
              end
              OP_STORE: begin
                if (rec_cnt_i >= NF) begin
                  status_o = ST_FULL;
                end else begin
                  wr_en_o   = 1'b1;
                  rec_cnt_o = rec_cnt_i + IW'(1);
                  status_o  = ST_STORED;
                end
              end
              default: begin
                nxt_o.target = start_tgt;
                nxt_o.phase  = PH_HOMING;
                play_idx_o   = '0;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
